[rtl/sphere_submerged_fraction_assert.svh]
// Assertion macros used by the top-level RTL module.
`ifndef SPHERE_SUBMERGED_FRACTION_ASSERT_SVH
`define SPHERE_SUBMERGED_FRACTION_ASSERT_SVH
`ifndef SYNTHESIS
`define SSF_ASSERT_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("ssf check failed");
`define SSF_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("ssf check failed");
`else
`define SSF_ASSERT_IMPLY(label, clk, rst, cond, prop)
`define SSF_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

[rtl/ssf_pkg.sv]
package ssf_pkg;

  localparam int MAX_BODIES_DEF = 1024;
  localparam int RW = 31;
  localparam int QW = 32;
  localparam int NCELLS = 32;
  localparam logic [16:0] FRAC_ONE = 17'd65536;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BAD_INDEX    = 2'd1,
    ST_NOT_SPHERE   = 2'd2,
    ST_SMALL_RADIUS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    K_ZERO = 2'd0,
    K_FULL = 2'd1,
    K_PART = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CFG_FLUID_LEVEL = 2'd0,
    CFG_BODY_COUNT  = 2'd1,
    CFG_RADIUS_TOL  = 2'd2,
    CFG_THRESHOLD   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic    valid;
    status_t status;
    logic    fixed;
    kind_t   kind;
  } side_t;

endpackage

[rtl/ssf_div_cell.sv]
module ssf_div_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  ssf_pkg::side_t            ctl_in,
  input  logic [ssf_pkg::RW-1:0]    rem_in,
  input  logic                      bit_in,
  input  logic [ssf_pkg::RW-1:0]    div_in,
  input  logic [ssf_pkg::QW-1:0]    quo_in,
  output ssf_pkg::side_t            ctl_out,
  output logic [ssf_pkg::RW-1:0]    rem_out,
  output logic [ssf_pkg::RW-1:0]    div_out,
  output logic [ssf_pkg::QW-1:0]    quo_out
);
  import ssf_pkg::*;

  logic [RW:0]   shifted;
  logic [RW+1:0] diff;
  logic          qbit;
  logic [RW-1:0] rem_next;

  // One restoring-division step: one quotient bit per cell.
  always_comb begin
    shifted  = {rem_in, bit_in};
    diff     = {1'b0, shifted} - {2'b00, div_in};
    qbit     = ~diff[RW+1];
    rem_next = qbit ? diff[RW-1:0] : shifted[RW-1:0];
  end

  always_ff @(posedge clk) begin
    ctl_out <= ctl_in;
    rem_out <= rem_next;
    div_out <= div_in;
    quo_out <= {quo_in[QW-2:0], qbit};
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end
  end

endmodule

[rtl/sphere_submerged_fraction.sv]
// Channel   Ports                                              Handshake
// input     body_index is_sphere body_fixed center_height      start & !busy
//           sphere_radius
// result    status submerged_fraction fully_submerged          done, one cycle
// config    cfg_index cfg_data                                 cfg_write
//
// A word is accepted every cycle; busy is always low.
// The pipeline holds one input stage, 32 divider cells (one quotient bit
// each), two multiply stages and the output register.
// Reset clears pipeline valid bits and sets config registers to defaults.
// The receiver cannot stall; results leave in input order.
module sphere_submerged_fraction #(
  parameter int MAX_BODIES = ssf_pkg::MAX_BODIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  body_index,
  input  logic        is_sphere,
  input  logic        body_fixed,
  input  logic signed [31:0] center_height,
  input  logic [30:0] sphere_radius,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [16:0] submerged_fraction,
  output logic        fully_submerged
);
  import ssf_pkg::*;
  `include "sphere_submerged_fraction_assert.svh"

  localparam logic [16:0] MaxB = 17'(MAX_BODIES);

  logic signed [31:0] fluid_level;
  logic [10:0] body_count;
  logic [15:0] radius_tolerance;
  logic [16:0] full_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      fluid_level      <= '0;
      body_count       <= '0;
      radius_tolerance <= 16'd1;
      full_threshold   <= 17'd65470;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FLUID_LEVEL: fluid_level      <= cfg_data;
        CFG_BODY_COUNT:  body_count       <= cfg_data[10:0];
        CFG_RADIUS_TOL:  radius_tolerance <= cfg_data[15:0];
        CFG_THRESHOLD:   full_threshold   <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic [16:0]        limit;
  logic signed [32:0] d;
  logic signed [32:0] rs;
  logic [32:0]        ysum;
  side_t              ctl_a;

  always_comb begin
    limit = ({6'd0, body_count} > MaxB) ? MaxB : {6'd0, body_count};
    d     = {fluid_level[31], fluid_level} - {center_height[31], center_height};
    rs    = {2'b00, sphere_radius};
    ysum  = d + rs;
    ctl_a.valid = start;
    ctl_a.fixed = body_fixed;
    ctl_a.kind  = K_ZERO;
    if ({7'd0, body_index} >= limit) begin
      ctl_a.status = ST_BAD_INDEX;
    end else if (!is_sphere) begin
      ctl_a.status = ST_NOT_SPHERE;
    end else if ({1'b0, sphere_radius} <= {16'd0, radius_tolerance}) begin
      ctl_a.status = ST_SMALL_RADIUS;
    end else begin
      ctl_a.status = ST_OK;
      if (d <= -rs) begin
        ctl_a.kind = K_ZERO;
      end else if (d >= rs) begin
        ctl_a.kind = K_FULL;
      end else begin
        ctl_a.kind = K_PART;
      end
    end
  end

  side_t         ctl[0:NCELLS];
  logic [RW-1:0] rem[0:NCELLS];
  logic [RW-1:0] dvs[0:NCELLS];
  logic [QW-1:0] quo[0:NCELLS];
  logic          y_lsb;

  always_ff @(posedge clk) begin
    ctl[0] <= ctl_a;
    rem[0] <= ysum[31:1];
    y_lsb  <= ysum[0];
    dvs[0] <= sphere_radius;
    quo[0] <= '0;
    if (rst) begin
      ctl[0].valid <= 1'b0;
    end
  end

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    ssf_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl[i]),
      .rem_in  (rem[i]),
      .bit_in  ((i == 0) ? y_lsb : 1'b0),
      .div_in  (dvs[i]),
      .quo_in  (quo[i]),
      .ctl_out (ctl[i+1]),
      .rem_out (rem[i+1]),
      .div_out (dvs[i+1]),
      .quo_out (quo[i+1])
    );
  end

  logic [63:0] sq;
  side_t       ctl_m1;
  logic [31:0] s32;
  logic [31:0] w30;
  logic [63:0] prod;
  side_t       ctl_m2;
  logic [16:0] frac_p;

  assign sq   = quo[NCELLS] * quo[NCELLS];
  assign prod = s32 * w30;

  always_ff @(posedge clk) begin
    ctl_m1 <= ctl[NCELLS];
    s32    <= sq[63:32];
    w30    <= 32'hC000_0000 - {1'b0, quo[NCELLS][31:1]};
    ctl_m2 <= ctl_m1;
    frac_p <= (prod[63:46] > {1'b0, FRAC_ONE}) ? FRAC_ONE : prod[62:46];
    if (rst) begin
      ctl_m1.valid <= 1'b0;
      ctl_m2.valid <= 1'b0;
    end
  end

  logic [16:0] frac_sel;

  always_comb begin
    case (ctl_m2.kind)
      K_PART:  frac_sel = frac_p;
      K_FULL:  frac_sel = FRAC_ONE;
      default: frac_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    status             <= ctl_m2.status;
    submerged_fraction <= frac_sel;
    fully_submerged    <= ((ctl_m2.status == ST_OK) || (ctl_m2.status == ST_SMALL_RADIUS))
                          && !ctl_m2.fixed && (frac_sel >= full_threshold);
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_m2.valid;
    end
  end

  `SSF_ASSERT_IMPLY(a_bad_zero, clk, rst, done && (status != ST_OK), submerged_fraction == '0)
  `SSF_ASSERT_IMPLY(a_frac_max, clk, rst, done, submerged_fraction <= FRAC_ONE)
  `SSF_ASSERT_IMPLY(a_full_ok, clk, rst, done && fully_submerged,
                    (status == ST_OK) || (status == ST_SMALL_RADIUS))
  `SSF_ASSERT_NEXT(a_enter, clk, rst, start, ctl[0].valid)

endmodule

[bench/sphere_submerged_fraction_test.sv]
module sphere_submerged_fraction_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ssf_pkg::*;

  localparam int LATENCY = 40;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [9:0]         idx;
    logic               sph;
    logic               fix;
    logic signed [31:0] ctr;
    logic [30:0]        rad;
  } query_t;

  typedef struct {
    status_t     st;
    logic [16:0] frac;
    logic        full;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [9:0] body_index = 0;
  logic is_sphere = 0;
  logic body_fixed = 0;
  logic signed [31:0] center_height = 0;
  logic [30:0] sphere_radius = 0;
  logic cfg_write = 0;
  logic [1:0] cfg_index = CFG_FLUID_LEVEL;
  logic [31:0] cfg_data = 0;
  logic done;
  logic [1:0] status;
  logic [16:0] submerged_fraction;
  logic fully_submerged;

  sphere_submerged_fraction dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Shadow copy of the configuration registers.
  logic signed [31:0] level_q = 0;
  logic [10:0] count_q = 0;
  logic [15:0] tol_q = 1;
  logic [16:0] thresh_q = 17'd65470;

  query_t pending_words[$];
  answer_t expected_answers[$];
  int idle_pct = 0;
  int errors = 0;
  int words_sent = 0;
  int answers_seen = 0;
  longint cycles = 0;
  logic word_taken = 0;

  task automatic queue_word(query_t q);
    pending_words = {pending_words, q};
  endtask

  function automatic logic [16:0] cap_share(longint d, longint r);
    bit [63:0] y, t, s, w, f;
    if (d <= -r) return 17'd0;
    if (d >= r) return FRAC_ONE;
    if (r == 0) return 17'd0;
    y = 64'(d + r);
    t = (y << 31) / 64'(r);
    if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
    s = (t * t) >> 32;
    w = (64'd3 << 30) - (t >> 1);
    f = (s * w) >> 46;
    if (f > 64'd65536) f = 64'd65536;
    return f[16:0];
  endfunction

  function automatic answer_t predict_fraction(query_t q);
    answer_t a;
    int lim;
    lim = (count_q > 1024) ? 1024 : int'(count_q);
    a.st = ST_OK;
    a.frac = 0;
    a.full = 0;
    if (int'(q.idx) >= lim) a.st = ST_BAD_INDEX;
    else if (!q.sph) a.st = ST_NOT_SPHERE;
    else begin
      if (q.rad <= 31'(tol_q)) a.st = ST_SMALL_RADIUS;
      else a.frac = cap_share(longint'(level_q) - longint'(q.ctr), longint'(q.rad));
      a.full = !q.fix && (a.frac >= thresh_q);
    end
    return a;
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      start <= 0;
    end else if (!(start && !word_taken)) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
        query_t q;
        q = pending_words.pop_front();
        body_index <= q.idx;
        is_sphere <= q.sph;
        body_fixed <= q.fix;
        center_height <= q.ctr;
        sphere_radius <= q.rad;
        start <= 1;
      end else begin
        start <= 0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else if (!rst) begin
      word_taken <= start && !busy;
      if (done) begin
        answers_seen <= answers_seen + 1;
        if (expected_answers.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result word: status %0d frac %0d full %0b",
                                    status, submerged_fraction, fully_submerged);
        end else begin
          answer_t e;
          e = expected_answers.pop_front();
          if (status !== e.st || submerged_fraction !== e.frac
              || fully_submerged !== e.full) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
                       e.st, e.frac, e.full, status, submerged_fraction,
                       fully_submerged);
          end
        end
      end
      if (start && !busy) begin
        query_t q;
        q.idx = body_index;
        q.sph = is_sphere;
        q.fix = body_fixed;
        q.ctr = center_height;
        q.rad = sphere_radius;
        expected_answers = {expected_answers, predict_fraction(q)};
        words_sent <= words_sent + 1;
      end
    end else begin
      word_taken <= 0;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 0;
    case (idx)
      CFG_FLUID_LEVEL: level_q = value;
      CFG_BODY_COUNT:  count_q = value[10:0];
      CFG_RADIUS_TOL:  tol_q = value[15:0];
      CFG_THRESHOLD:   thresh_q = value[16:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [31:0] lvl, logic [31:0] cnt, logic [31:0] tol,
                          logic [31:0] thr);
    write_reg(CFG_FLUID_LEVEL, lvl);
    write_reg(CFG_BODY_COUNT, cnt);
    write_reg(CFG_RADIUS_TOL, tol);
    write_reg(CFG_THRESHOLD, thr);
  endtask

  task automatic drain;
    while (pending_words.size() > 0 || start || expected_answers.size() > 0)
      @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic query_t make_word(logic [9:0] i, logic s, logic f, longint c,
                                       longint r);
    query_t q;
    q.idx = i;
    q.sph = s;
    q.fix = f;
    if (c > 64'sh7FFF_FFFF) c = 64'sh7FFF_FFFF;
    if (c < -64'sh8000_0000) c = -64'sh8000_0000;
    q.ctr = c[31:0];
    q.rad = r[30:0];
    return q;
  endfunction

  function automatic query_t random_word();
    longint r, d;
    int lim, k;
    logic [9:0] i;
    lim = (count_q > 1024) ? 1024 : int'(count_q);
    if (lim > 0 && $urandom_range(9) > 0) i = 10'($urandom_range(lim - 1));
    else i = 10'($urandom);
    case ($urandom_range(3))
      0: r = tol_q + $urandom_range(2) - 1;
      1: r = $urandom & 32'h7FFF_FFFF;
      default: begin
        k = $urandom_range(31, 1);
        r = $urandom & ((64'd1 << k) - 1);
      end
    endcase
    if (r < 0) r = 0;
    if ($urandom_range(7) == 0) return make_word(i, $urandom_range(9) > 0, 1'($urandom),
                                                 longint'($signed($urandom)), r);
    d = longint'($urandom_range(2 * 1000)) - 1000;
    d = (r > 0 && $urandom_range(3) > 0) ? (longint'($urandom) % (2 * r + 5)) - r - 2 : d;
    return make_word(i, $urandom_range(9) > 0, 1'($urandom), longint'(level_q) - d, r);
  endfunction

  task automatic random_phase(int n, int pct);
    idle_pct = pct;
    repeat (n) queue_word(random_word());
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Reset configuration: no rows are valid yet.
    queue_word(make_word(0, 1, 0, 0, 65536));
    queue_word(make_word(10'h3FF, 0, 1, 0, 65536));
    drain();

    set_regs(0, 1024, 1, 65470);
    queue_word(make_word(0, 1, 0, 0, 65536));
    queue_word(make_word(1023, 1, 0, 0, 65536));
    queue_word(make_word(5, 0, 0, 0, 65536));
    queue_word(make_word(5, 1, 0, 0, 0));
    queue_word(make_word(5, 1, 0, 0, 1));
    queue_word(make_word(5, 1, 0, 0, 2));
    queue_word(make_word(5, 1, 0, 65536, 65536));
    queue_word(make_word(5, 1, 0, -65536, 65536));
    queue_word(make_word(5, 1, 0, 65535, 65536));
    queue_word(make_word(5, 1, 0, -65535, 65536));
    queue_word(make_word(5, 1, 1, -65536, 65536));
    queue_word(make_word(5, 1, 0, 32'sh7FFF_FFFF, 31'h7FFF_FFFF));
    queue_word(make_word(5, 1, 0, -64'sh8000_0000, 31'h7FFF_FFFF));
    queue_word(make_word(5, 1, 0, -64'sh8000_0000, 2));
    queue_word(make_word(5, 1, 0, 32'sh7FFF_FFFF, 2));
    queue_word(make_word(5, 1, 0, 1, 3));
    queue_word(make_word(1023, 0, 1, -1, 31'h7FFF_FFFF));
    drain();
    random_phase(70, 0);

    set_regs($urandom, 2047, 0, 0);
    queue_word(make_word(1023, 1, 0, 0, 0));
    queue_word(make_word(1023, 1, 1, 0, 0));
    random_phase(70, 73);

    set_regs(32'h8000_0000, 1, 65535, 65536);
    queue_word(make_word(1, 1, 0, 0, 65536));
    queue_word(make_word(0, 1, 0, -64'sh8000_0000, 65535));
    queue_word(make_word(0, 1, 0, -64'sh8000_0000, 65536));
    random_phase(60, 18);

    set_regs(32'h7FFF_FFFF, 500, 100, 131071);
    random_phase(70, 0);

    set_regs($urandom, 1024, 1, 32768);
    random_phase(80, 73);

    set_regs(0, 700, 16, 65470);
    random_phase(80, 18);

    $display("covered %0d query words and %0d result words over six register settings",
             words_sent, answers_seen);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatching result words", errors);
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
